// ----- hw/rtl/gjmi_pkg.sv -----
// ----------------------------------------------------------------------------
// gjmi_pkg
// Shared types, constants and arithmetic helpers for the Gauss-Jordan inverter.
// ----------------------------------------------------------------------------
package gjmi_pkg;

  localparam int MAX_DIM_DEF = 8;
  localparam int WORD_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int PROD_W      = 2 * WORD_W - FRAC_W;  // magnitude after fraction drop
  localparam int IDX_W       = 4;                    // row/column field in commands
  localparam int SIZE_W      = 4;
  localparam int LIMIT_W     = 31;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 31;

  localparam logic [SIZE_W-1:0]     SIZE_RESET  = SIZE_W'(4);
  localparam logic [LIMIT_W-1:0]    LIMIT_RESET = LIMIT_W'(1);
  localparam logic [WORD_W-1:0]     ONE_Q       = WORD_W'(1) << FRAC_W;
  localparam logic [WORD_W-1:0]     HI_Q        = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0]     LO_Q        = {1'b1, {(WORD_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SINGULAR_LIMIT = CFG_IDX_W'(1);

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_IDENT,
    OP_SRCH,
    OP_SWAP_RD,
    OP_SWAP_W1,
    OP_SWAP_W2,
    OP_DIV_RD,
    OP_DIV_WR,
    OP_F_RD,
    OP_ELIM,
    OP_OUT_RD,
    OP_OUT_SING
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] row_a;
    logic [IDX_W-1:0] row_b;
    logic [IDX_W-1:0] col;
    logic             flag;
  } cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0] best;
    logic [IDX_W-1:0]  piv;
    logic              div_done;
    logic              elim_busy;
    logic              out_busy;
  } sts_t;

  function automatic logic [WORD_W-1:0] mag(input logic [WORD_W-1:0] x);
    return x[WORD_W-1] ? (~x + 1'b1) : x;
  endfunction

  // signed saturation of a sign and magnitude to one word
  function automatic logic [WORD_W-1:0] sat_mag(input logic neg,
                                                input logic [PROD_W-1:0] m);
    if (m > {{(PROD_W-WORD_W){1'b0}}, HI_Q}) begin
      return neg ? LO_Q : HI_Q;
    end
    return neg ? (~m[WORD_W-1:0] + 1'b1) : m[WORD_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/gjmi_if.sv -----
// ----------------------------------------------------------------------------
// gjmi_if
// Valid/ready channels for matrix elements and inverse results.
// ----------------------------------------------------------------------------
interface gjmi_elem_if;
  logic                              valid;
  logic                              ready;
  logic signed [gjmi_pkg::WORD_W-1:0] element;

  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface

interface gjmi_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [gjmi_pkg::WORD_W-1:0] value;
  logic                              singular;
  logic                              last;

  modport source (output valid, output value, output singular, output last, input ready);
  modport sink   (input valid, input value, input singular, input last, output ready);
endinterface

// ----- hw/rtl/gjmi_div.sv -----
// ----------------------------------------------------------------------------
// gjmi_div
// Restoring divider, one quotient bit per cycle: a * 2^16 / p, rounded
// half away from zero, saturated to one word.
// ----------------------------------------------------------------------------
module gjmi_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [gjmi_pkg::WORD_W-1:0] dividend,
  input  logic [gjmi_pkg::WORD_W-1:0] divisor,
  output logic                        done,
  output logic [gjmi_pkg::WORD_W-1:0] quot
);
  localparam int W     = gjmi_pkg::WORD_W;
  localparam int NUM_W = gjmi_pkg::WORD_W + gjmi_pkg::FRAC_W;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic             fin;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     rem;
  logic [W-1:0]     dsr;
  logic [NUM_W-1:0] sh;
  logic             neg;

  logic [W:0]       trial;
  logic             take;
  logic             up;

  always_comb begin
    trial = {rem, sh[NUM_W-1]};
    take  = trial >= {1'b0, dsr};
    up    = {rem, 1'b0} >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        sh   <= {gjmi_pkg::mag(dividend), {gjmi_pkg::FRAC_W{1'b0}}};
        dsr  <= gjmi_pkg::mag(divisor);
        neg  <= dividend[W-1] ^ divisor[W-1];
        rem  <= '0;
        cnt  <= CNT_W'(NUM_W);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= take ? W'(trial - {1'b0, dsr}) : trial[W-1:0];
        sh  <= {sh[NUM_W-2:0], take};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        quot <= gjmi_pkg::sat_mag(neg, sh + NUM_W'(up));
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/gjmi_dp.sv -----
// ----------------------------------------------------------------------------
// gjmi_dp
// Datapath: augmented store, pivot search, divider, multiply-subtract
// pipeline and output register.
// ----------------------------------------------------------------------------
module gjmi_dp #(
  parameter int MAX_DIM = gjmi_pkg::MAX_DIM_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  gjmi_pkg::cmd_t              cmd,
  input  logic [gjmi_pkg::WORD_W-1:0] element,
  input  logic                        out_ready,
  output gjmi_pkg::sts_t              sts,
  output logic                        out_valid,
  output logic [gjmi_pkg::WORD_W-1:0] out_value,
  output logic                        out_singular,
  output logic                        out_last
);
  localparam int W     = gjmi_pkg::WORD_W;
  localparam int ROW_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int COL_W = $clog2(2 * MAX_DIM);
  localparam int AW    = ROW_W + COL_W;
  localparam int DEPTH = 2 ** AW;

  logic [W-1:0] mem [DEPTH];

  logic [AW-1:0] addr_a, addr_b, wr_addr;
  logic [W-1:0]  wr_data;
  logic          wr_en, rd_en_a, rd_en_b;
  logic [W-1:0]  rd_a_q, rd_b_q;

  // delayed actions on registered read data
  logic             srch_d, srch_first;
  logic [ROW_W-1:0] srch_row;
  logic             div_d, f_d, out_d, out_last_d;
  logic [W-1:0]     best, pv, f;
  logic [ROW_W-1:0] piv;

  // multiply-subtract pipeline
  logic          e1_v, e2_v, e3_v;
  logic [AW-1:0] e1_addr, e2_addr, e3_addr;
  logic [2*W-1:0] p2;
  logic          n2;
  logic [W-1:0]  a2, a3, m3;
  logic [2*W-1:0] rnd;
  logic [W:0]    diff;
  logic [W-1:0]  sub_q;

  logic          div_done;
  logic [W-1:0]  div_q;

  assign addr_a = {cmd.row_a[ROW_W-1:0], cmd.col[COL_W-1:0]};
  assign addr_b = {cmd.row_b[ROW_W-1:0], cmd.col[COL_W-1:0]};

  always_comb begin
    rd_en_a = 1'b0;
    rd_en_b = 1'b0;
    case (cmd.op)
      gjmi_pkg::OP_SRCH, gjmi_pkg::OP_DIV_RD, gjmi_pkg::OP_F_RD,
      gjmi_pkg::OP_OUT_RD: rd_en_a = 1'b1;
      gjmi_pkg::OP_SWAP_RD, gjmi_pkg::OP_ELIM: begin
        rd_en_a = 1'b1;
        rd_en_b = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    rnd   = p2 + (2*W)'(1 << (gjmi_pkg::FRAC_W - 1));
    diff  = {a3[W-1], a3} - {m3[W-1], m3};
    sub_q = (diff[W] != diff[W-1]) ? (diff[W] ? gjmi_pkg::LO_Q : gjmi_pkg::HI_Q)
                                   : diff[W-1:0];
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = addr_a;
    wr_data = element;
    if (e3_v) begin
      wr_addr = e3_addr;
      wr_data = sub_q;
    end else begin
      case (cmd.op)
        gjmi_pkg::OP_LOAD:    wr_data = element;
        gjmi_pkg::OP_IDENT:   wr_data = cmd.flag ? gjmi_pkg::ONE_Q : '0;
        gjmi_pkg::OP_SWAP_W1: wr_data = rd_b_q;
        gjmi_pkg::OP_SWAP_W2: begin
          wr_addr = addr_b;
          wr_data = rd_a_q;
        end
        gjmi_pkg::OP_DIV_WR:  wr_data = div_q;
        default:              wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en_a) begin
      rd_a_q <= mem[addr_a];
    end
    if (rd_en_b) begin
      rd_b_q <= mem[addr_b];
    end
  end

  gjmi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_d),
    .dividend (rd_a_q),
    .divisor  (pv),
    .done     (div_done),
    .quot     (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      srch_d    <= 1'b0;
      div_d     <= 1'b0;
      f_d       <= 1'b0;
      out_d     <= 1'b0;
      e1_v      <= 1'b0;
      e2_v      <= 1'b0;
      e3_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      srch_d     <= cmd.op == gjmi_pkg::OP_SRCH;
      srch_first <= cmd.flag;
      srch_row   <= cmd.row_a[ROW_W-1:0];
      div_d      <= cmd.op == gjmi_pkg::OP_DIV_RD;
      f_d        <= cmd.op == gjmi_pkg::OP_F_RD;
      out_d      <= cmd.op == gjmi_pkg::OP_OUT_RD;
      out_last_d <= cmd.flag;
      e1_v       <= cmd.op == gjmi_pkg::OP_ELIM;
      e1_addr    <= addr_a;
      e2_v       <= e1_v;
      e3_v       <= e2_v;

      if (srch_d && (srch_first || gjmi_pkg::mag(rd_a_q) > best)) begin
        best <= gjmi_pkg::mag(rd_a_q);
        pv   <= rd_a_q;
        piv  <= srch_row;
      end
      if (f_d) begin
        f <= rd_a_q;
      end

      p2      <= (2*W)'(gjmi_pkg::mag(f)) * (2*W)'(gjmi_pkg::mag(rd_b_q));
      n2      <= f[W-1] ^ rd_b_q[W-1];
      a2      <= rd_a_q;
      e2_addr <= e1_addr;
      m3      <= gjmi_pkg::sat_mag(n2, rnd[2*W-1:gjmi_pkg::FRAC_W]);
      a3      <= a2;
      e3_addr <= e2_addr;

      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (out_d) begin
        out_valid    <= 1'b1;
        out_value    <= rd_a_q;
        out_singular <= 1'b0;
        out_last     <= out_last_d;
      end else if (cmd.op == gjmi_pkg::OP_OUT_SING) begin
        out_valid    <= 1'b1;
        out_value    <= '0;
        out_singular <= 1'b1;
        out_last     <= 1'b1;
      end
    end
  end

  always_comb begin
    sts.best      = best;
    sts.piv       = gjmi_pkg::IDX_W'(piv);
    sts.div_done  = div_done;
    sts.elim_busy = e1_v | e2_v | e3_v;
    sts.out_busy  = out_valid | out_d;
  end

endmodule

// ----- hw/rtl/gjmi_ctrl.sv -----
// ----------------------------------------------------------------------------
// gjmi_ctrl
// Sequencer: loading, identity fill, per-column pivot/swap/scale/eliminate,
// and result readout. Holds the configuration registers.
// ----------------------------------------------------------------------------
module gjmi_ctrl #(
  parameter int MAX_DIM = gjmi_pkg::MAX_DIM_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [gjmi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gjmi_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  gjmi_pkg::sts_t                  sts,
  output gjmi_pkg::cmd_t                  cmd
);
  localparam int ROW_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int COL_W = $clog2(2 * MAX_DIM);
  localparam int NW    = $clog2(MAX_DIM + 1);
  localparam int IW    = gjmi_pkg::IDX_W;

  typedef enum logic [4:0] {
    S_LOAD, S_IDENT, S_SRCH, S_SRCH_WAIT, S_SRCH_CHK, S_SWAP_RD, S_SWAP_W1,
    S_SWAP_W2, S_DIV_RD, S_DIV_WAIT, S_ROW_NEXT, S_F_RD, S_ELIM, S_DRAIN,
    S_OUT, S_SING
  } state_t;

  state_t                          state;
  logic [gjmi_pkg::SIZE_W-1:0]     size;
  logic [gjmi_pkg::LIMIT_W-1:0]    limit;
  logic [ROW_W-1:0]                r, pc;
  logic [COL_W-1:0]                j;

  logic [NW-1:0]    n;
  logic [ROW_W-1:0] nm1;
  logic [COL_W-1:0] wm1, ncol, lcol;
  logic [ROW_W-1:0] piv;
  logic             out_last;

  always_comb begin
    if (size == '0) begin
      n = NW'(1);
    end else if (32'(size) > MAX_DIM) begin
      n = NW'(MAX_DIM);
    end else begin
      n = NW'(size);
    end
    nm1      = ROW_W'(n - 1'b1);
    ncol     = COL_W'(n);
    wm1      = COL_W'({n, 1'b0} - 1'b1);
    lcol     = COL_W'(nm1);
    piv      = sts.piv[ROW_W-1:0];
    out_last = (r == nm1) && (j == wm1);
    in_ready = state == S_LOAD;
  end

  always_comb begin
    cmd       = '0;
    cmd.op    = gjmi_pkg::OP_NOP;
    cmd.row_a = IW'(r);
    cmd.row_b = IW'(pc);
    cmd.col   = IW'(j);
    unique case (state)
      S_LOAD:    if (in_valid) cmd.op = gjmi_pkg::OP_LOAD;
      S_IDENT: begin
        cmd.op   = gjmi_pkg::OP_IDENT;
        cmd.flag = j == ncol + COL_W'(r);
      end
      S_SRCH: begin
        cmd.op   = gjmi_pkg::OP_SRCH;
        cmd.col  = IW'(pc);
        cmd.flag = r == pc;
      end
      S_SWAP_RD, S_SWAP_W1, S_SWAP_W2: begin
        cmd.op    = (state == S_SWAP_RD) ? gjmi_pkg::OP_SWAP_RD :
                    (state == S_SWAP_W1) ? gjmi_pkg::OP_SWAP_W1 : gjmi_pkg::OP_SWAP_W2;
        cmd.row_a = IW'(pc);
        cmd.row_b = IW'(piv);
      end
      S_DIV_RD: begin
        cmd.op    = gjmi_pkg::OP_DIV_RD;
        cmd.row_a = IW'(pc);
      end
      S_DIV_WAIT: begin
        cmd.row_a = IW'(pc);
        if (sts.div_done) cmd.op = gjmi_pkg::OP_DIV_WR;
      end
      S_F_RD: begin
        cmd.op  = gjmi_pkg::OP_F_RD;
        cmd.col = IW'(pc);
      end
      S_ELIM:    cmd.op = gjmi_pkg::OP_ELIM;
      S_OUT: begin
        cmd.flag = out_last;
        if (!sts.out_busy) cmd.op = gjmi_pkg::OP_OUT_RD;
      end
      S_SING:    if (!sts.out_busy) cmd.op = gjmi_pkg::OP_OUT_SING;
      S_SRCH_WAIT, S_SRCH_CHK, S_ROW_NEXT, S_DRAIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      size  <= gjmi_pkg::SIZE_RESET;
      limit <= gjmi_pkg::LIMIT_RESET;
      r     <= '0;
      j     <= '0;
      pc    <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_valid) begin
            if (j == lcol) begin
              j <= '0;
              if (r == nm1) begin
                r     <= '0;
                j     <= ncol;
                state <= S_IDENT;
              end else begin
                r <= r + 1'b1;
              end
            end else begin
              j <= j + 1'b1;
            end
          end
        end
        S_IDENT: begin
          if (j == wm1) begin
            j <= ncol;
            if (r == nm1) begin
              r     <= '0;
              pc    <= '0;
              state <= S_SRCH;
            end else begin
              r <= r + 1'b1;
            end
          end else begin
            j <= j + 1'b1;
          end
        end
        S_SRCH: begin
          if (r == nm1) state <= S_SRCH_WAIT;
          else r <= r + 1'b1;
        end
        S_SRCH_WAIT: state <= S_SRCH_CHK;
        S_SRCH_CHK: begin
          j <= '0;
          if (sts.best == '0 || sts.best < {1'b0, limit}) state <= S_SING;
          else if (piv != pc) state <= S_SWAP_RD;
          else state <= S_DIV_RD;
        end
        S_SWAP_RD: state <= S_SWAP_W1;
        S_SWAP_W1: state <= S_SWAP_W2;
        S_SWAP_W2: begin
          if (j == wm1) begin
            j     <= '0;
            state <= S_DIV_RD;
          end else begin
            j     <= j + 1'b1;
            state <= S_SWAP_RD;
          end
        end
        S_DIV_RD: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (sts.div_done) begin
            if (j == wm1) begin
              r     <= '0;
              state <= S_ROW_NEXT;
            end else begin
              j     <= j + 1'b1;
              state <= S_DIV_RD;
            end
          end
        end
        S_ROW_NEXT: begin
          if (r == pc) begin
            if (r == nm1) begin
              if (pc == nm1) begin
                r     <= '0;
                j     <= ncol;
                state <= S_OUT;
              end else begin
                pc    <= pc + 1'b1;
                r     <= pc + 1'b1;
                state <= S_SRCH;
              end
            end else begin
              r <= r + 1'b1;
            end
          end else begin
            j     <= '0;
            state <= S_F_RD;
          end
        end
        S_F_RD: state <= S_ELIM;
        S_ELIM: begin
          if (j == wm1) state <= S_DRAIN;
          else j <= j + 1'b1;
        end
        S_DRAIN: begin
          if (!sts.elim_busy) begin
            if (r == nm1) begin
              if (pc == nm1) begin
                r     <= '0;
                j     <= ncol;
                state <= S_OUT;
              end else begin
                pc    <= pc + 1'b1;
                r     <= pc + 1'b1;
                state <= S_SRCH;
              end
            end else begin
              r     <= r + 1'b1;
              state <= S_ROW_NEXT;
            end
          end
        end
        S_OUT: begin
          if (!sts.out_busy) begin
            if (out_last) begin
              r     <= '0;
              j     <= '0;
              state <= S_LOAD;
            end else if (j == wm1) begin
              j <= ncol;
              r <= r + 1'b1;
            end else begin
              j <= j + 1'b1;
            end
          end
        end
        S_SING: begin
          if (!sts.out_busy) begin
            r     <= '0;
            j     <= '0;
            state <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase

      if (cfg_we) begin
        unique case (cfg_index)
          gjmi_pkg::REG_MATRIX_SIZE: begin
            size <= cfg_data[gjmi_pkg::SIZE_W-1:0];
            r    <= '0;
            j    <= '0;
          end
          gjmi_pkg::REG_SINGULAR_LIMIT: limit <= cfg_data[gjmi_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- hw/rtl/gauss_jordan_matrix_inverse_core.sv -----
// ----------------------------------------------------------------------------
// gauss_jordan_matrix_inverse_core
// Q16.16 matrix inverse by Gauss-Jordan elimination with partial pivoting.
// ----------------------------------------------------------------------------
// Loading takes one element per cycle; no results until the n*n-th element.
// Run time after the last element is dominated by the bit-serial divider
// (2n elements of the pivot row per column), plus any row swaps; then results
// go out one at a time, each only after the previous one is taken.
// A new matrix is taken only after the previous run has been issued.
// Synchronous active-high reset: size 4, singular limit 1; store is not cleared.
module gauss_jordan_matrix_inverse_core #(
  parameter int MAX_DIM = gjmi_pkg::MAX_DIM_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [gjmi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gjmi_pkg::CFG_DATA_W-1:0] cfg_data,
  gjmi_elem_if.sink                       element_ch,
  gjmi_result_if.source                   result_ch
);
  gjmi_pkg::cmd_t cmd;
  gjmi_pkg::sts_t sts;
  logic [gjmi_pkg::WORD_W-1:0] value;

  gjmi_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (element_ch.valid),
    .in_ready  (element_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gjmi_dp #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .element      (element_ch.element),
    .out_ready    (result_ch.ready),
    .sts          (sts),
    .out_valid    (result_ch.valid),
    .out_value    (value),
    .out_singular (result_ch.singular),
    .out_last     (result_ch.last)
  );

  assign result_ch.value = value;

endmodule

// ----- hw/rtl/gjmi_checker.sv -----
// ----------------------------------------------------------------------------
// gjmi_checker
// Port-level checks on the result channel.
// ----------------------------------------------------------------------------
module gjmi_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [gjmi_pkg::WORD_W-1:0] out_value,
  input logic                        out_singular,
  input logic                        out_last
);

  // a singular verdict is a single, final, zero-valued transaction
  a_sing_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_singular |-> out_last && out_value == '0)
    else $error("singular result not last or nonzero");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) &&
                                $stable(out_singular) && $stable(out_last))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind gauss_jordan_matrix_inverse_core gjmi_checker u_gjmi_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result_ch.valid),
  .out_ready    (result_ch.ready),
  .out_value    (result_ch.value),
  .out_singular (result_ch.singular),
  .out_last     (result_ch.last)
);

// ----- test/gauss_jordan_matrix_inverse_core_tb.sv -----
// ----------------------------------------------------------------------------
// gauss_jordan_matrix_inverse_core_tb
// Self-checking bench for the Q16.16 Gauss-Jordan inverter: streams matrices
// of many sizes and pivot limits, predicts every inverse element or singular
// flag with a fixed-point elimination of its own, and checks each transaction.
// ----------------------------------------------------------------------------
module gauss_jordan_matrix_inverse_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint HI_W = 64'sd2147483647;
  localparam longint LO_W = -64'sd2147483648;
  localparam int     HOLD_CYCLES = 1500;
  localparam int     SETTLE = 60;

  typedef struct {
    logic signed [gjmi_pkg::WORD_W-1:0] value;
    logic                               singular;
    logic                               last;
  } inv_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [gjmi_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [gjmi_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  gjmi_elem_if   elem_ch ();
  gjmi_result_if res_ch ();

  gauss_jordan_matrix_inverse_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .element_ch (elem_ch.sink),
    .result_ch  (res_ch.source)
  );

  // stimulus and expectations
  logic signed [gjmi_pkg::WORD_W-1:0] elem_q[$];
  inv_word_t                          inverse_q[$];
  int sent_cnt = 0;
  int taken_cnt = 0;
  int err_cnt = 0;
  int src_idle_pct = 23;
  int snk_idle_pct = 84;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int hold_cnt = 0;

  // predictor state
  logic [gjmi_pkg::SIZE_W-1:0]  mdl_size = gjmi_pkg::SIZE_RESET;
  logic [gjmi_pkg::LIMIT_W-1:0] mdl_limit = gjmi_pkg::LIMIT_RESET;
  longint                       aug[8][16];
  int                           fill_cnt = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic longint unsigned mag64(longint x);
    return x < 0 ? longint'(-x) : longint'(x);
  endfunction

  function automatic longint sat_word(bit neg, longint unsigned m);
    if (m > longint'(HI_W)) return neg ? LO_W : HI_W;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint unsigned p;
    p = (mag64(a) * mag64(b) + 64'd32768) >> gjmi_pkg::FRAC_W;
    return sat_word((a < 0) != (b < 0), p);
  endfunction

  function automatic longint fx_div(longint a, longint p);
    longint unsigned num, mp, q, r;
    num = mag64(a) << gjmi_pkg::FRAC_W;
    mp  = mag64(p);
    q = num / mp;
    r = num % mp;
    if (r >= mp - r) q++;  // round half away from zero
    return sat_word((a < 0) != (p < 0), q);
  endfunction

  function automatic longint fx_sub(longint a, longint b);
    longint d;
    d = a - b;
    if (d > HI_W) return HI_W;
    if (d < LO_W) return LO_W;
    return d;
  endfunction

  function automatic int eff_dim();
    if (mdl_size == 0) return 1;
    if (mdl_size > 8) return 8;
    return int'(mdl_size);
  endfunction

  // full elimination once the last element is in; queues the inverse or a singular verdict
  task automatic invert_and_expect(int n);
    int piv;
    longint unsigned best, m;
    longint pv, f;
    inv_word_t w;
    for (int r = 0; r < n; r++)
      for (int j = 0; j < n; j++) aug[r][n+j] = (r == j) ? 64'sd65536 : 64'sd0;
    for (int c = 0; c < n; c++) begin
      piv = c;
      best = mag64(aug[c][c]);
      for (int r = c + 1; r < n; r++) begin
        m = mag64(aug[r][c]);
        if (m > best) begin
          best = m;
          piv = r;
        end
      end
      if (best == 0 || best < mdl_limit) begin
        w.value = '0;
        w.singular = 1'b1;
        w.last = 1'b1;
        inverse_q.push_back(w);
        return;
      end
      if (piv != c) begin
        for (int j = 0; j < 2*n; j++) begin
          f = aug[c][j];
          aug[c][j] = aug[piv][j];
          aug[piv][j] = f;
        end
      end
      pv = aug[c][c];
      for (int j = 0; j < 2*n; j++) aug[c][j] = fx_div(aug[c][j], pv);
      for (int r = 0; r < n; r++) begin
        if (r != c) begin
          f = aug[r][c];
          for (int j = 0; j < 2*n; j++) aug[r][j] = fx_sub(aug[r][j], fx_mul(f, aug[c][j]));
        end
      end
    end
    for (int i = 0; i < n*n; i++) begin
      w.value = aug[i/n][n + i%n][gjmi_pkg::WORD_W-1:0];
      w.singular = 1'b0;
      w.last = (i == n*n - 1);
      inverse_q.push_back(w);
    end
  endtask

  task automatic absorb_element(logic signed [gjmi_pkg::WORD_W-1:0] e);
    int n;
    n = eff_dim();
    if (fill_cnt >= n*n) fill_cnt = 0;
    aug[fill_cnt/n][fill_cnt%n] = longint'(e);
    fill_cnt++;
    if (fill_cnt == n*n) begin
      fill_cnt = 0;
      invert_and_expect(n);
    end
  endtask

  task automatic report_mismatch(string field, longint want, longint got);
    $display("mismatch %s: expected %0d got %0d at %0t", field, want, got, $time);
    err_cnt++;
  endtask

  // element driver
  always @(posedge clk) begin
    if (rst) begin
      elem_ch.valid <= 1'b0;
      elem_ch.element <= '0;
    end else begin
      if (elem_ch.valid && elem_ch.ready) begin
        absorb_element(elem_ch.element);
        taken_cnt++;
      end
      if (!elem_ch.valid || elem_ch.ready) begin
        if (elem_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          elem_ch.valid <= 1'b1;
          elem_ch.element <= elem_q.pop_front();
        end else begin
          elem_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver stall, timed in cycles on its own
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt >= HOLD_CYCLES - 1) hold_done <= 1'b1;
    end
  end

  // result monitor and back-pressure
  always @(posedge clk) begin
    inv_word_t w;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (inverse_q.size() == 0) begin
          report_mismatch("unexpected transaction, value", 0, res_ch.value);
        end else begin
          w = inverse_q.pop_front();
          if (res_ch.value !== w.value) report_mismatch("value", w.value, res_ch.value);
          if (res_ch.singular !== w.singular)
            report_mismatch("singular", w.singular, res_ch.singular);
          if (res_ch.last !== w.last) report_mismatch("last", w.last, res_ch.last);
        end
      end
      if (hold_go && !hold_done) begin
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  task automatic push_elem(logic signed [gjmi_pkg::WORD_W-1:0] e);
    elem_q.push_back(e);
    sent_cnt++;
  endtask

  task automatic wait_idle();
    wait (taken_cnt == sent_cnt && inverse_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [gjmi_pkg::CFG_IDX_W-1:0] idx,
                           logic [gjmi_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == gjmi_pkg::REG_MATRIX_SIZE) begin
      mdl_size = data[gjmi_pkg::SIZE_W-1:0];
      fill_cnt = 0;
    end else begin
      mdl_limit = data[gjmi_pkg::LIMIT_W-1:0];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random matrix: mostly well conditioned, some singular, some raw noise
  task automatic push_matrix(int n);
    int kind, dup;
    logic signed [gjmi_pkg::WORD_W-1:0] m[8][8];
    kind = int'($urandom_range(9));
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) begin
        if (kind <= 5) begin
          if (r == c) m[r][c] = $urandom_range(32'h0010_0000, 32'h0001_0000);
          else m[r][c] = $urandom_range(32'h0000_8000);
          if ($urandom_range(1)) m[r][c] = -m[r][c];
        end else if (kind == 9) begin
          m[r][c] = $urandom();
        end else begin
          m[r][c] = $signed(32'($urandom_range(32'h0004_0000))) - 32'sh0002_0000;
        end
      end
    if ((kind == 7 || kind == 8) && n > 1) begin
      dup = int'($urandom_range(n-1, 1));
      for (int c = 0; c < n; c++) m[dup][c] = m[0][c];
    end
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) push_elem(m[r][c]);
  endtask

  initial begin
    int sizes[12];
    int n, mats;
    sizes = '{1, 2, 3, 4, 5, 6, 7, 8, 0, 15, 2, 3};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // one-by-one: unity, most negative, most positive, tiny, zero, minus one
    write_reg(gjmi_pkg::REG_MATRIX_SIZE, 1);
    write_reg(gjmi_pkg::REG_SINGULAR_LIMIT, 1);
    push_elem(32'sh0001_0000);
    push_elem(32'sh8000_0000);
    push_elem(32'sh7FFF_FFFF);
    push_elem(32'sd1);
    push_elem(32'sd0);
    push_elem(-32'sd1);
    wait_idle();
    // zero pivot is singular even with a zero limit
    write_reg(gjmi_pkg::REG_SINGULAR_LIMIT, 0);
    push_elem(32'sd0);
    push_elem(32'sd1);
    wait_idle();
    write_reg(gjmi_pkg::REG_SINGULAR_LIMIT, 31'h7FFF_FFFF);
    push_elem(32'sh7FFF_FFFF);
    push_elem(32'sh7FFF_FFFE);
    wait_idle();
    // 2x2: row swap, equal-magnitude pivots, then a partial load dropped by a resize
    write_reg(gjmi_pkg::REG_SINGULAR_LIMIT, 1);
    write_reg(gjmi_pkg::REG_MATRIX_SIZE, 2);
    push_elem(0); push_elem(32'sh0001_0000); push_elem(32'sh0001_0000); push_elem(0);
    push_elem(32'sh0001_0000); push_elem(32'sh0002_0000);
    push_elem(-32'sh0001_0000); push_elem(32'sh0003_0000);
    push_elem(32'sh0005_0000); push_elem(32'sh0001_0000); push_elem(7);
    wait_idle();
    write_reg(gjmi_pkg::REG_MATRIX_SIZE, 3);
    push_matrix(3);
    wait_idle();

    for (int p = 0; p < 12; p++) begin
      if (p < 4) begin
        src_idle_pct = 23;
        snk_idle_pct = 84;
      end else if (p < 8) begin
        src_idle_pct = 84;
        snk_idle_pct = 23;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      write_reg(gjmi_pkg::REG_MATRIX_SIZE, gjmi_pkg::CFG_DATA_W'(sizes[p]));
      case ($urandom_range(5))
        0: write_reg(gjmi_pkg::REG_SINGULAR_LIMIT, 0);
        1: write_reg(gjmi_pkg::REG_SINGULAR_LIMIT,
                     gjmi_pkg::CFG_DATA_W'($urandom_range(32'h0002_0000)));
        default: write_reg(gjmi_pkg::REG_SINGULAR_LIMIT, 1);
      endcase
      n = eff_dim();
      mats = (24 / (n*n) > 0) ? 24 / (n*n) : 1;
      if (p == 10) hold_go = 1'b1;  // sink stalls while several matrices queue up
      for (int k = 0; k < mats; k++) push_matrix(n);
      wait_idle();
    end

    repeat (SETTLE) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
